>>> hdl/hilbert_envelope_detector_unit_assert.svh
// ---------------------------------------------------------------------------
// Hilbert envelope detector assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef HILBERT_ENVELOPE_DETECTOR_UNIT_ASSERT_SVH
`define HILBERT_ENVELOPE_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define HED_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HED_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/hed_pkg.sv
// ---------------------------------------------------------------------------
// Hilbert envelope detector package
// Fixed widths, the Hilbert tap coefficient table and the sequencer states.
// ---------------------------------------------------------------------------
package hed_pkg;

    localparam int ENV_W       = 17;
    localparam int COEF_W      = 16;
    localparam int COEF_CNT    = 32;
    localparam int COEF_IDX_W  = 5;
    localparam int FRAC_W      = 16;

    localparam logic [ENV_W-1:0] ENV_MAX = '1;

    // round(65536 * 2 / (pi * k)) for odd k = 1, 3, ..., 63.
    localparam logic [COEF_W-1:0] HIL_COEF [COEF_CNT] = '{
        16'd41722, 16'd13907, 16'd8344, 16'd5960, 16'd4636, 16'd3793, 16'd3209, 16'd2781,
        16'd2454,  16'd2196,  16'd1987, 16'd1814, 16'd1669, 16'd1545, 16'd1439, 16'd1346,
        16'd1264,  16'd1192,  16'd1128, 16'd1070, 16'd1018, 16'd970,  16'd927,  16'd888,
        16'd851,   16'd818,   16'd787,  16'd759,  16'd732,  16'd707,  16'd684,  16'd662
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CENTER,
        ST_TAPS,
        ST_DRAIN,
        ST_ROUND,
        ST_SQ_X,
        ST_SQ_H,
        ST_SQ_DRAIN,
        ST_ROOT_WAIT,
        ST_EMIT
    } hed_state_t;

endpackage

>>> hdl/hilbert_envelope_detector_unit.sv
// ---------------------------------------------------------------------------
// Hilbert envelope detector
// Streams signed samples in on the input channel (sample, last) and sends
// envelope values out on the output channel (envelope, last_res), both with
// valid/ready transfers. Once ODD_LAG_LIMIT samples of a signal are in, each
// input transfer yields one envelope for the sample ODD_LAG_LIMIT places back.
// A transfer with last set flushes all pending centers, the final one marked
// by last_res, and then starts a fresh signal with an empty history.
// Each envelope takes one pass of the shared multiplier over the odd tap
// pairs, two squaring passes, and the square root unit that delivers one
// bit per cycle over ROOT_W bits, the wider of SAMPLE_BITS+3 and 17.
// in_ready is high only while the sequencer is idle; an item that yields
// no envelope frees it the next cycle.
// A finished envelope sits in the output register, so a stalled receiver only
// holds up the sequencer once the next envelope is ready to be written.
// Reset empties the history (a fill count marks older samples as zero) and
// drops any envelope that has not been transferred.
// ---------------------------------------------------------------------------
`include "hilbert_envelope_detector_unit_assert.svh"

module hilbert_envelope_detector_unit
    import hed_pkg::*;
#(
    parameter int ODD_LAG_LIMIT = 31,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ENV_W-1:0]              envelope,
    output logic                          last_res
);

    // Storage and datapath sizes.
    localparam int DEPTH  = 2 * ODD_LAG_LIMIT + 1;
    localparam int AW     = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int MW     = (ODD_LAG_LIMIT > 1) ? $clog2(ODD_LAG_LIMIT + 1) : 1;
    localparam int NK     = (ODD_LAG_LIMIT + 1) / 2;
    localparam int KW     = (NK > 1) ? $clog2(NK) : 1;
    localparam int MUL_W  = (SAMPLE_BITS + 3 > 17) ? SAMPLE_BITS + 3 : 17;
    localparam int ACC_W  = 2 * MUL_W + 1;
    localparam int ROOT_W = MUL_W;

    localparam logic [MW-1:0]           M_LAST     = MW'(ODD_LAG_LIMIT);
    localparam logic [KW-1:0]           K_LAST     = KW'(NK - 1);
    localparam logic [FILL_W-1:0]       FILL_FULL  = FILL_W'(DEPTH);
    localparam logic [AW-1:0]           HEAD_LAST  = AW'(DEPTH - 1);
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(2 ** (FRAC_W - 1));

    // Sequencer and history bookkeeping.
    hed_state_t        state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [MW-1:0]     seen_reg, seen_next;
    logic [MW-1:0]     m_reg, m_next;
    logic              last_item_reg, last_item_next;
    logic [KW-1:0]     kidx_reg, kidx_next;

    // Control strobes from the sequencer.
    logic in_fire;
    logic issue_rd;
    logic rd_center;
    logic acc_clr;
    logic load_h;
    logic sq_x;
    logic sq_h;
    logic root_start;
    logic load_res;
    logic load_out;
    logic pipe_busy;
    logic final_emit;

    // History memory, newest sample at head_reg.
    logic signed [SAMPLE_BITS-1:0] line_mem [DEPTH];
    logic [AW-1:0]                 head_inc;

    // Tap read stage.
    logic [AW-1:0]                 off;
    logic [AW-1:0]                 pos_a, pos_b;
    logic                          ok_a, ok_b;
    logic [AW-1:0]                 addr_a, addr_b;
    logic signed [SAMPLE_BITS-1:0] rd_a_reg, rd_b_reg;
    logic                          ok_a_reg, ok_b_reg;
    logic [COEF_W-1:0]             coef_reg;
    logic                          rvld_reg, rcen_reg;

    // Difference, multiply and accumulate stages.
    logic signed [SAMPLE_BITS-1:0] tap_a, tap_b;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [MUL_W-1:0]       op_a_reg, op_b_reg;
    logic                          opv_reg, opv_next;
    logic signed [2*MUL_W-1:0]     prod_reg;
    logic                          pv_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       rnd_sum;
    logic signed [ACC_W-1:0]       h_full;
    logic signed [MUL_W-1:0]       h_reg;

    // Root and output.
    logic                          root_done;
    logic [ROOT_W-1:0]             root_val;
    logic [ENV_W-1:0]              res_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [ENV_W-1:0]              env_reg;
    logic                          last_res_reg;

    // Memory address of the sample held at delay position pos.
    function automatic logic [AW-1:0] line_addr(input logic [AW-1:0] head,
                                                input logic [AW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, head} + (AW+1)'(DEPTH) - {1'b0, pos};
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign in_fire   = in_valid && in_ready;
    assign pipe_busy = rvld_reg || opv_reg || pv_reg;
    assign head_inc  = (head_reg == HEAD_LAST) ? '0 : head_reg + 1'b1;

    // ---------------------------------------------------------------------
    // Sequencer: next state.
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (last || seen_reg == M_LAST))
                begin
                    state_next = ST_CENTER;
                end
            end
            ST_CENTER:
            begin
                state_next = ST_TAPS;
            end
            ST_TAPS:
            begin
                if (kidx_reg == K_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                state_next = ST_SQ_X;
            end
            ST_SQ_X:
            begin
                state_next = ST_SQ_H;
            end
            ST_SQ_H:
            begin
                state_next = ST_SQ_DRAIN;
            end
            ST_SQ_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_ROOT_WAIT;
                end
            end
            ST_ROOT_WAIT:
            begin
                if (root_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    state_next = (last_item_reg && m_reg != '0) ? ST_CENTER : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer: control outputs.
    // ---------------------------------------------------------------------
    always_comb
    begin
        in_ready   = 1'b0;
        issue_rd   = 1'b0;
        rd_center  = 1'b0;
        acc_clr    = 1'b0;
        load_h     = 1'b0;
        sq_x       = 1'b0;
        sq_h       = 1'b0;
        root_start = 1'b0;
        load_res   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_CENTER:
            begin
                issue_rd  = 1'b1;
                rd_center = 1'b1;
                acc_clr   = 1'b1;
            end
            ST_TAPS:
            begin
                issue_rd = 1'b1;
            end
            ST_ROUND:
            begin
                load_h  = 1'b1;
                acc_clr = 1'b1;
            end
            ST_SQ_X:
            begin
                sq_x = 1'b1;
            end
            ST_SQ_H:
            begin
                sq_h = 1'b1;
            end
            ST_SQ_DRAIN:
            begin
                root_start = !pipe_busy;
            end
            ST_ROOT_WAIT:
            begin
                load_res = root_done;
            end
            ST_EMIT:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign final_emit = load_out && last_item_reg && (m_reg == '0);

    // ---------------------------------------------------------------------
    // Bookkeeping: write pointer, fill count, samples seen, current center.
    // ---------------------------------------------------------------------
    always_comb
    begin
        head_next      = head_reg;
        fill_next      = fill_reg;
        seen_next      = seen_reg;
        m_next         = m_reg;
        last_item_next = last_item_reg;
        kidx_next      = (state_reg == ST_TAPS) ? kidx_reg + 1'b1 : '0;
        if (in_fire)
        begin
            head_next      = head_inc;
            fill_next      = (fill_reg == FILL_FULL) ? fill_reg : fill_reg + 1'b1;
            last_item_next = last;
            // The steady-state center comes first; otherwise a flush starts
            // at the oldest sample of a short signal.
            m_next         = seen_reg;
            if (last)
            begin
                seen_next = '0;
            end
            else if (seen_reg != M_LAST)
            begin
                seen_next = seen_reg + 1'b1;
            end
        end
        if (load_out && last_item_reg && m_reg != '0)
        begin
            m_next = m_reg - 1'b1;
        end
        // After the final flushed envelope the history reads as empty.
        if (final_emit)
        begin
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            seen_reg      <= '0;
            m_reg         <= '0;
            last_item_reg <= 1'b0;
            kidx_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            seen_reg      <= seen_next;
            m_reg         <= m_next;
            last_item_reg <= last_item_next;
            kidx_reg      <= kidx_next;
        end
    end

    // ---------------------------------------------------------------------
    // Tap addressing: the center reads position m, each odd lag k reads the
    // pair m+k and m-k. Positions past the fill count read as zero, and so
    // does a later position beyond the newest sample.
    // ---------------------------------------------------------------------
    assign off    = rd_center ? '0 : AW'({kidx_reg, 1'b1});
    assign pos_a  = AW'(m_reg) + off;
    assign pos_b  = AW'(m_reg) - off;
    assign ok_a   = FILL_W'(pos_a) < fill_reg;
    assign ok_b   = !rd_center && (AW'(m_reg) >= off) && (FILL_W'(pos_b) < fill_reg);
    assign addr_a = line_addr(head_reg, pos_a);
    assign addr_b = line_addr(head_reg, pos_b);

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            line_mem[head_inc] <= sample;
        end
        if (issue_rd)
        begin
            rd_a_reg <= line_mem[addr_a];
            rd_b_reg <= line_mem[addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_rd)
        begin
            ok_a_reg <= ok_a;
            ok_b_reg <= ok_b;
            coef_reg <= HIL_COEF[COEF_IDX_W'(kidx_reg)];
            rcen_reg <= rd_center;
        end
    end

    // ---------------------------------------------------------------------
    // Shared multiply-accumulate: tap products first, then the two squares.
    // ---------------------------------------------------------------------
    assign tap_a    = ok_a_reg ? rd_a_reg : '0;
    assign tap_b    = ok_b_reg ? rd_b_reg : '0;
    assign diff     = {tap_a[SAMPLE_BITS-1], tap_a} - {tap_b[SAMPLE_BITS-1], tap_b};
    assign opv_next = (rvld_reg && !rcen_reg) || sq_x || sq_h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvld_reg <= 1'b0;
            opv_reg  <= 1'b0;
            pv_reg   <= 1'b0;
        end
        else
        begin
            rvld_reg <= issue_rd;
            opv_reg  <= opv_next;
            pv_reg   <= opv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rvld_reg && rcen_reg)
        begin
            x_reg <= tap_a;
        end
        if (rvld_reg && !rcen_reg)
        begin
            op_a_reg <= MUL_W'(diff);
            op_b_reg <= MUL_W'(coef_reg);
        end
        else if (sq_x)
        begin
            op_a_reg <= MUL_W'(x_reg);
            op_b_reg <= MUL_W'(x_reg);
        end
        else if (sq_h)
        begin
            op_a_reg <= h_reg;
            op_b_reg <= h_reg;
        end
        prod_reg <= op_a_reg * op_b_reg;
        if (acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (load_h)
        begin
            h_reg <= MUL_W'(h_full);
        end
    end

    // Round the tap sum back by FRAC_W bits, halves toward plus infinity.
    assign rnd_sum = acc_reg + ROUND_BIAS;
    assign h_full  = rnd_sum >>> FRAC_W;

    // ---------------------------------------------------------------------
    // Square root of x*x + h*h, saturated to the envelope width.
    // ---------------------------------------------------------------------
    hed_isqrt #(
        .ROOT_W (ROOT_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (acc_reg[2*MUL_W-1:0]),
        .done     (root_done),
        .root     (root_val)
    );

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_reg <= (root_val > ROOT_W'(ENV_MAX)) ? ENV_MAX : root_val[ENV_W-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Output register.
    // ---------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            env_reg      <= res_reg;
            last_res_reg <= last_item_reg && (m_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign envelope  = env_reg;
    assign last_res  = last_res_reg;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    `HED_ASSERT_IMP(a_round_after_drain, state_reg == ST_ROUND, !pipe_busy,
        "tap sum rounded before the pipeline drained")
    `HED_ASSERT_IMP(a_work_has_history, state_reg != ST_IDLE, fill_reg != '0,
        "envelope work with an empty history")
    `HED_ASSERT_IMP(a_plain_item_center, (state_reg != ST_IDLE) && !last_item_reg,
        m_reg == M_LAST, "non-final item works on a center other than the steady one")
    `HED_ASSERT_NXT(a_fill_cleared, final_emit, fill_reg == '0,
        "history not emptied after the final envelope")

endmodule

>>> hdl/hed_isqrt.sv
// ---------------------------------------------------------------------------
// Iterative integer square root
// Floor square root, one result bit per cycle, restoring bit-pair method.
// ---------------------------------------------------------------------------
module hed_isqrt #(
    parameter int ROOT_W = 19
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [2*ROOT_W-1:0]   radicand,
    output logic                  done,
    output logic [ROOT_W-1:0]     root
);

    localparam int CW = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

    logic [2*ROOT_W-1:0] rad_reg, rad_next;
    logic [ROOT_W+1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [ROOT_W+1:0]   rem_shift;
    logic [ROOT_W+1:0]   trial;
    logic                fits;

    // Bring down the next two radicand bits and try appending a one.
    assign rem_shift = {rem_reg[ROOT_W-1:0], rad_reg[2*ROOT_W-1:2*ROOT_W-2]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = busy_reg && (cnt_reg == '0);
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(ROOT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[2*ROOT_W-3:0], 2'b00};
            rem_next  = fits ? (rem_shift - trial) : rem_shift;
            root_next = {root_reg[ROOT_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
